// File: sv/whtlp_pkg.sv
// Shared types and constants for the word hash table core.
// No dependencies.
`default_nettype none
package whtlp_pkg;

  localparam int SIZE_W      = 11;
  localparam int SEED_W      = 32;
  localparam int STEP_W      = 10;
  localparam int STATUS_W    = 3;
  localparam int SLOT_OUT_W  = 10;
  localparam int COUNT_OUT_W = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int OP_W        = 1;
  localparam int BYTE_W      = 8;
  localparam int MOD_CNT_W   = 6;

  localparam int DEF_TABLE_DEPTH    = 1024;
  localparam int DEF_MAX_WORD_BYTES = 32;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 11'd1021;
  localparam logic [SEED_W-1:0] HASH_SEED_RST  = 32'd0;
  localparam logic [STEP_W-1:0] PROBE_STEP_RST = 10'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_ABSENT   = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_SIZE = 2'd0,
    REG_HASH_SEED  = 2'd1,
    REG_PROBE_STEP = 2'd2
  } cfg_reg_t;

  localparam logic [OP_W-1:0] OP_INSERT = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD_STEP,
    S_MOD_HOME,
    S_PROBE_ADDR,
    S_PROBE_CHK,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: sv/word_hash_table_linear_probe_core.sv
// Word hash table core: byte-serial hashing, shared restoring modulo unit,
// linear-probe lookup/insert over on-chip tables. Depends on whtlp_pkg.
`default_nettype none
// Usage:
//   in_*  : one word byte per beat; in_last_byte closes the word, and the
//           in_operation given with it selects search or search+insert.
//   out_* : one result beat per word (status, slot, element count).
//   cfg_* : register writes (index, data), always ready; write only when idle.
// Timing: non-final bytes are taken one per cycle. A final byte starts the
//   sequencer: probe_step mod size and then the home slot, both on one
//   bit-per-cycle restoring modulo unit, then each probe as a registered
//   table read followed by a compare, then the output register is loaded.
//   A too-long word skips all of that and goes straight to the output
//   register. in_ready is low while the word end is being processed.
// Reset: a clearing pass writes every slot's valid/length entry to empty,
//   with in_ready low; cfg writes are taken meanwhile.
// Stall: a result waits in the output register; a later result waits in
//   the sequencer until the output register is free.
module word_hash_table_linear_probe_core #(
  parameter int TABLE_DEPTH    = whtlp_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_WORD_BYTES = whtlp_pkg::DEF_MAX_WORD_BYTES
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [whtlp_pkg::OP_W-1:0]          in_operation,
  input  wire logic [whtlp_pkg::BYTE_W-1:0]        in_word_byte,
  input  wire logic                                in_last_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [whtlp_pkg::STATUS_W-1:0]           out_status,
  output logic [whtlp_pkg::SLOT_OUT_W-1:0]         out_slot,
  output logic [whtlp_pkg::COUNT_OUT_W-1:0]        out_element_count,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [whtlp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [whtlp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import whtlp_pkg::*;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_W   = $clog2(MAX_WORD_BYTES + 2);
  localparam int KEY_W   = MAX_WORD_BYTES * BYTE_W;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int META_W  = LEN_W + 1;
  localparam int SUM_W   = SIZE_W + 1;

  // configuration
  logic [SIZE_W-1:0] table_size_r;
  logic [SEED_W-1:0] hash_seed_r;
  logic [STEP_W-1:0] probe_step_r;

  state_t state_r, state_nxt;

  logic [SEED_W-1:0]                      hash_r;
  logic [MAX_WORD_BYTES-1:0][BYTE_W-1:0]  buf_r;
  logic [LEN_W-1:0]                       wlen_r;
  logic [OP_W-1:0]                        op_r;
  logic [SIZE_W-1:0]                      size_r;
  logic [SIZE_W-1:0]                      step_r;
  logic [IDX_W-1:0]                       s_r;
  logic [IDX_W-1:0]                       home_r;
  logic [SIZE_W-1:0]                      k_r;
  logic [CNT_W-1:0]                       count_r;
  logic [IDX_W-1:0]                       clr_r;
  logic [STATUS_W-1:0]                    res_status_r;
  logic [IDX_W-1:0]                       res_slot_r;

  // shared modulo unit
  logic [SEED_W-1:0]    div_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [MOD_CNT_W-1:0] bits_r;
  logic [SUM_W-1:0]     rem_shift;
  logic [SIZE_W-1:0]    rem_nxt;
  logic                 mod_done;

  // tables
  logic [META_W-1:0] meta_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
  logic [META_W-1:0] meta_q_r;
  logic [KEY_W-1:0]  key_q_r;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [META_W-1:0] meta_wdata;
  logic              key_we;

  logic              in_fire, out_fire, word_end;
  logic [SEED_W-1:0] h_cur, h_nxt, c_ext;
  logic [SIZE_W-1:0] size_use;
  logic              entry_valid, entry_match, probe_last, out_free;
  logic [SUM_W-1:0]  next_sum;
  logic [IDX_W-1:0]  next_s;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign word_end = in_fire && in_last_byte;
  assign out_free = !out_valid || out_ready;

  // hash fold: h ^= (h << 5) + c + (h >> 2)
  assign h_cur = (wlen_r == '0) ? hash_seed_r : hash_r;
  assign c_ext = {{(SEED_W - BYTE_W){in_word_byte[BYTE_W-1]}}, in_word_byte};
  assign h_nxt = h_cur ^ ((h_cur << 5) + c_ext + (h_cur >> 2));

  always_comb begin
    if (table_size_r == '0) begin
      size_use = SIZE_W'(1);
    end else if (32'(table_size_r) > 32'(TABLE_DEPTH)) begin
      size_use = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_use = table_size_r;
    end
  end

  assign rem_shift = {rem_r, div_r[SEED_W-1]};
  assign rem_nxt   = (rem_shift >= {1'b0, size_r}) ? SIZE_W'(rem_shift - {1'b0, size_r})
                                                   : SIZE_W'(rem_shift);
  assign mod_done  = bits_r == MOD_CNT_W'(1);

  assign entry_valid = meta_q_r[META_W-1];
  assign entry_match = entry_valid && (meta_q_r[LEN_W-1:0] == wlen_r) && (key_q_r == buf_r);
  assign probe_last  = k_r == (size_r - SIZE_W'(1));
  assign next_sum    = SUM_W'(s_r) + SUM_W'(step_r);
  assign next_s      = (next_sum >= {1'b0, size_r}) ? IDX_W'(next_sum - {1'b0, size_r})
                                                    : IDX_W'(next_sum);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == IDX_W'(TABLE_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (word_end) begin
          if (wlen_r >= LEN_W'(MAX_WORD_BYTES)) state_nxt = S_EMIT;
          else                                   state_nxt = S_MOD_STEP;
        end
      end
      S_MOD_STEP: begin
        if (mod_done) state_nxt = S_MOD_HOME;
      end
      S_MOD_HOME: begin
        if (mod_done) state_nxt = S_PROBE_ADDR;
      end
      S_PROBE_ADDR: state_nxt = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (!entry_valid || entry_match || probe_last) state_nxt = S_EMIT;
        else                                           state_nxt = S_PROBE_ADDR;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = state_r == S_IDLE;
    cfg_ready  = 1'b1;
    mem_we     = 1'b0;
    key_we     = 1'b0;
    mem_waddr  = s_r;
    meta_wdata = {1'b1, wlen_r};
    unique case (state_r)
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_r;
        meta_wdata = '0;
      end
      S_PROBE_CHK: begin
        if (!entry_valid && op_r == OP_INSERT) begin
          mem_we = 1'b1;
          key_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) meta_mem[mem_waddr] <= meta_wdata;
    if (key_we) key_mem[mem_waddr] <= buf_r;
    meta_q_r <= meta_mem[s_r];
    key_q_r  <= key_mem[s_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RST;
      hash_seed_r  <= HASH_SEED_RST;
      probe_step_r <= PROBE_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TABLE_SIZE: table_size_r <= cfg_data[SIZE_W-1:0];
        REG_HASH_SEED:  hash_seed_r  <= cfg_data[SEED_W-1:0];
        REG_PROBE_STEP: probe_step_r <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      wlen_r    <= '0;
      buf_r     <= '0;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // the emit state reloads the output register itself
      if (out_fire && state_r != S_EMIT) out_valid <= 1'b0;
      unique case (state_r)
        S_CLEAR: clr_r <= clr_r + IDX_W'(1);
        S_IDLE: begin
          if (in_fire) begin
            hash_r <= h_nxt;
            for (int i = 0; i < MAX_WORD_BYTES; i++) begin
              if (wlen_r == LEN_W'(i)) buf_r[i] <= in_word_byte;
            end
            if (wlen_r <= LEN_W'(MAX_WORD_BYTES)) wlen_r <= wlen_r + LEN_W'(1);
            op_r   <= in_operation;
            size_r <= size_use;
            div_r  <= {probe_step_r, {(SEED_W - STEP_W){1'b0}}};
            rem_r  <= '0;
            bits_r <= MOD_CNT_W'(STEP_W);
            res_status_r <= ST_TOO_LONG;
            res_slot_r   <= '0;
          end
        end
        S_MOD_STEP: begin
          rem_r  <= rem_nxt;
          div_r  <= div_r << 1;
          bits_r <= bits_r - MOD_CNT_W'(1);
          if (mod_done) begin
            step_r <= rem_nxt;
            rem_r  <= '0;
            div_r  <= {hash_r[SEED_W-2:0], 1'b0};
            bits_r <= MOD_CNT_W'(SEED_W - 1);
          end
        end
        S_MOD_HOME: begin
          rem_r  <= rem_nxt;
          div_r  <= div_r << 1;
          bits_r <= bits_r - MOD_CNT_W'(1);
          if (mod_done) begin
            s_r    <= IDX_W'(rem_nxt);
            home_r <= IDX_W'(rem_nxt);
            k_r    <= '0;
          end
        end
        S_PROBE_ADDR: begin
        end
        S_PROBE_CHK: begin
          if (!entry_valid) begin
            res_slot_r <= s_r;
            if (op_r == OP_INSERT) begin
              res_status_r <= ST_INSERTED;
              count_r      <= count_r + CNT_W'(1);
            end else begin
              res_status_r <= ST_ABSENT;
            end
          end else if (entry_match) begin
            res_slot_r   <= s_r;
            res_status_r <= ST_FOUND;
          end else if (probe_last) begin
            res_slot_r   <= home_r;
            res_status_r <= ST_FULL;
          end else begin
            s_r <= next_s;
            k_r <= k_r + SIZE_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_status        <= res_status_r;
            out_slot          <= SLOT_OUT_W'(res_slot_r);
            out_element_count <= COUNT_OUT_W'(count_r);
            wlen_r            <= '0;
            buf_r             <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("stored count above table depth");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE_CHK |-> (k_r < size_r) && (32'(s_r) < 32'(size_r)))
    else $error("probe index or slot out of range");

  a_too_long_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TOO_LONG |-> out_slot == '0)
    else $error("too-long word reported a slot");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE_CHK && !entry_valid && op_r == OP_INSERT
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not bump count");

  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready && !out_valid)
    else $error("channel active during clearing pass");
`endif

endmodule
`default_nettype wire
